// ===== design/tpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the two-class strict priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

	localparam int CLASS_DEPTH_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int DATA_W  = 32;
	localparam int OCC_W   = 6;

	localparam logic [1:0] PRIO_HIGH = 2'd1;
	localparam logic [1:0] PRIO_LOW  = 2'd2;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADPRIO = 2'd3
	} status_t;

	// Control carried alongside the memory read into the output stage.
	typedef struct packed {
		logic             deq_hi;
		logic             deq_lo;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} tpq_ctl_t;

endpackage

// ===== design/tpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module tpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/two_class_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue_top
// Strict two-class priority queue: two FIFO rings held in RAM, high class
// served first on dequeue, one result beat for every request beat.
// ----------------------------------------------------------------------------
// The queue takes one request per clock while in_stall is low and returns one
// result beat for each, through the registered RAM read of the dequeued entry
// and then the output register. Both classes live in their own
// RAM of CLASS_DEPTH entries; the pointers and counts sit in flip-flops, so
// every request is decided at acceptance and back-to-back requests never touch
// the same entry in the same cycle. A stall on the output side backs up
// through the read stage to the input after two beats are held. Entries are
// never read before they are written, so no clearing pass follows reset.
module two_class_priority_queue_top #(
	parameter int CLASS_DEPTH = tpq_pkg::CLASS_DEPTH_DEF,
	parameter int VALUE_WIDTH = tpq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic signed [tpq_pkg::DATA_W-1:0] value,
	input  logic [1:0]                priority_req,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [tpq_pkg::DATA_W-1:0] data_out,
	output logic [1:0]                status,
	output logic [tpq_pkg::OCC_W-1:0] occupancy
);

	import tpq_pkg::*;

	localparam int PTR_W = $clog2(CLASS_DEPTH);
	localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
	localparam int EXT_W = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CLASS_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CLASS_DEPTH);

	logic [PTR_W-1:0] hi_rd_q, hi_wr_q, lo_rd_q, lo_wr_q;
	logic [CNT_W-1:0] hi_cnt_q, lo_cnt_q;
	logic [PTR_W-1:0] hi_rd_d, hi_wr_d, lo_rd_d, lo_wr_d;
	logic [CNT_W-1:0] hi_cnt_d, lo_cnt_d;

	logic                   accept;
	logic                   s1_advance;
	logic                   valid_s1;
	tpq_ctl_t               ctl_s1;
	tpq_ctl_t               ctl_d;
	logic                   wr_hi, wr_lo, rd_hi, rd_lo;
	logic [VALUE_WIDTH-1:0] wr_val;
	logic [VALUE_WIDTH-1:0] hi_rdata, lo_rdata;
	logic [VALUE_WIDTH-1:0] sel_rdata;
	logic [EXT_W-1:0]       value_ext, rdata_ext;
	logic [CNT_W:0]         occ_sum;

	logic                   out_valid_q;
	logic [DATA_W-1:0]      data_q;
	status_t                status_q;
	logic [OCC_W-1:0]       occ_q;

	// The read stage moves on whenever the output register is free or drains.
	assign s1_advance = !out_valid_q || !out_stall;
	assign in_stall   = valid_s1 && !s1_advance;
	assign accept     = in_valid && !in_stall;

	assign value_ext = EXT_W'(value);
	assign wr_val    = value_ext[VALUE_WIDTH-1:0];

	always_comb begin
		hi_rd_d  = hi_rd_q;
		hi_wr_d  = hi_wr_q;
		lo_rd_d  = lo_rd_q;
		lo_wr_d  = lo_wr_q;
		hi_cnt_d = hi_cnt_q;
		lo_cnt_d = lo_cnt_q;
		wr_hi    = 1'b0;
		wr_lo    = 1'b0;
		rd_hi    = 1'b0;
		rd_lo    = 1'b0;
		ctl_d.status = ST_OK;

		if (mode == MODE_ENQ) begin
			case (priority_req)
				PRIO_HIGH: begin
					if (hi_cnt_q == CNT_FULL) begin
						ctl_d.status = ST_FULL;
					end else begin
						wr_hi = 1'b1;
					end
				end
				PRIO_LOW: begin
					if (lo_cnt_q == CNT_FULL) begin
						ctl_d.status = ST_FULL;
					end else begin
						wr_lo = 1'b1;
					end
				end
				default: begin
					ctl_d.status = ST_BADPRIO;
				end
			endcase
		end else begin
			if (hi_cnt_q != '0) begin
				rd_hi = 1'b1;
			end else if (lo_cnt_q != '0) begin
				rd_lo = 1'b1;
			end else begin
				ctl_d.status = ST_EMPTY;
			end
		end

		if (wr_hi) begin
			hi_wr_d  = (hi_wr_q == PTR_LAST) ? '0 : hi_wr_q + 1'b1;
			hi_cnt_d = hi_cnt_q + 1'b1;
		end
		if (wr_lo) begin
			lo_wr_d  = (lo_wr_q == PTR_LAST) ? '0 : lo_wr_q + 1'b1;
			lo_cnt_d = lo_cnt_q + 1'b1;
		end
		if (rd_hi) begin
			hi_rd_d  = (hi_rd_q == PTR_LAST) ? '0 : hi_rd_q + 1'b1;
			hi_cnt_d = hi_cnt_q - 1'b1;
		end
		if (rd_lo) begin
			lo_rd_d  = (lo_rd_q == PTR_LAST) ? '0 : lo_rd_q + 1'b1;
			lo_cnt_d = lo_cnt_q - 1'b1;
		end

		occ_sum         = {1'b0, hi_cnt_d} + {1'b0, lo_cnt_d};
		ctl_d.occupancy = OCC_W'(occ_sum);
		ctl_d.deq_hi    = rd_hi;
		ctl_d.deq_lo    = rd_lo;
	end

	tpq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CLASS_DEPTH)
	) u_hi_ram (
		.clk     (clk),
		.wr_en   (accept && wr_hi),
		.wr_addr (hi_wr_q),
		.wr_data (wr_val),
		.rd_en   (accept && rd_hi),
		.rd_addr (hi_rd_q),
		.rd_data (hi_rdata)
	);

	tpq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CLASS_DEPTH)
	) u_lo_ram (
		.clk     (clk),
		.wr_en   (accept && wr_lo),
		.wr_addr (lo_wr_q),
		.wr_data (wr_val),
		.rd_en   (accept && rd_lo),
		.rd_addr (lo_rd_q),
		.rd_data (lo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_rd_q  <= '0;
			hi_wr_q  <= '0;
			lo_rd_q  <= '0;
			lo_wr_q  <= '0;
			hi_cnt_q <= '0;
			lo_cnt_q <= '0;
		end else if (accept) begin
			hi_rd_q  <= hi_rd_d;
			hi_wr_q  <= hi_wr_d;
			lo_rd_q  <= lo_rd_d;
			lo_wr_q  <= lo_wr_d;
			hi_cnt_q <= hi_cnt_d;
			lo_cnt_q <= lo_cnt_d;
		end
	end

	// The RAM read data holds until the next accepted request, so this stage
	// can wait on a stalled output without losing the dequeued value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
		end
	end

	assign sel_rdata = ctl_s1.deq_hi ? hi_rdata : lo_rdata;
	assign rdata_ext = EXT_W'(signed'(sel_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && valid_s1) begin
			data_q   <= (ctl_s1.deq_hi || ctl_s1.deq_lo) ? rdata_ext[DATA_W-1:0] : '0;
			status_q <= ctl_s1.status;
			occ_q    <= ctl_s1.occupancy;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign status    = status_q;
	assign occupancy = occ_q;

endmodule

// ===== tb/sv/two_class_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue_top_tb
// Self-checking bench for the two-class strict priority queue.
// A short table of directed requests covers reset state, bad priority codes,
// extreme values, service order and a full class. Random phases of filling,
// draining and mixed traffic follow. Each result beat is checked field by
// field against the table row or an in-bench model of both rings. Random
// idle and stall bursts are placed on both channels.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top_tb;
	import tpq_pkg::*;

	localparam int          QUEUE_DEPTH    = CLASS_DEPTH_DEF;
	localparam int          RANDOM_ITEMS   = 450;
	localparam int          CALM_TAIL      = 60;
	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          DRAIN_CYCLES   = 8;
	localparam logic [1:0]  PRIO_BAD_ZERO  = 2'd0;
	localparam logic [1:0]  PRIO_BAD_THREE = 2'd3;

	typedef enum int {PH_FILL_HIGH, PH_FILL_LOW, PH_DRAIN, PH_MIXED} phase_kind_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		status_t                  stat;
		logic [OCC_W-1:0]         occ;
	} tpq_result_t;

	typedef struct packed {
		logic              op;
		logic [DATA_W-1:0] val;
		logic [1:0]        prio;
		logic [4:0]        reps;
		logic              typed;
		logic [DATA_W-1:0] data;
		status_t           stat;
		logic [OCC_W-1:0]  occ;
	} tpq_row_t;

	// Rows that repeat send an incrementing value; their results come from the model.
	tpq_row_t dir_rows [0:12] = '{
		'{MODE_DEQ, 32'h0000_0000, PRIO_BAD_ZERO,  5'd1,  1'b1, 32'h0000_0000, ST_EMPTY,   6'd0},
		'{MODE_ENQ, 32'h5555_5555, PRIO_BAD_ZERO,  5'd1,  1'b1, 32'h0000_0000, ST_BADPRIO, 6'd0},
		'{MODE_ENQ, 32'hAAAA_AAAA, PRIO_BAD_THREE, 5'd1,  1'b1, 32'h0000_0000, ST_BADPRIO, 6'd0},
		'{MODE_ENQ, 32'h8000_0000, PRIO_LOW,       5'd1,  1'b1, 32'h0000_0000, ST_OK,      6'd1},
		'{MODE_ENQ, 32'h7FFF_FFFF, PRIO_HIGH,      5'd1,  1'b1, 32'h0000_0000, ST_OK,      6'd2},
		'{MODE_ENQ, 32'hFFFF_FFFF, PRIO_LOW,       5'd1,  1'b1, 32'h0000_0000, ST_OK,      6'd3},
		'{MODE_DEQ, 32'hFFFF_FFFF, PRIO_BAD_THREE, 5'd1,  1'b1, 32'h7FFF_FFFF, ST_OK,      6'd2},
		'{MODE_DEQ, 32'h0000_0000, PRIO_LOW,       5'd1,  1'b1, 32'h8000_0000, ST_OK,      6'd1},
		'{MODE_ENQ, 32'h0000_0001, PRIO_HIGH,      5'd16, 1'b0, 32'h0000_0000, ST_OK,      6'd0},
		'{MODE_ENQ, 32'h0000_0000, PRIO_HIGH,      5'd1,  1'b1, 32'h0000_0000, ST_FULL,    6'd17},
		'{MODE_ENQ, 32'hFFFF_FFFF, PRIO_BAD_ZERO,  5'd1,  1'b1, 32'h0000_0000, ST_BADPRIO, 6'd17},
		'{MODE_DEQ, 32'h0000_0000, PRIO_HIGH,      5'd1,  1'b1, 32'h0000_0001, ST_OK,      6'd16},
		'{MODE_DEQ, 32'h1234_5678, PRIO_LOW,       5'd1,  1'b0, 32'h0000_0000, ST_OK,      6'd0}
	};

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      in_valid     = 1'b0;
	logic                      in_stall;
	logic                      mode         = MODE_ENQ;
	logic signed [DATA_W-1:0]  value        = '0;
	logic [1:0]                priority_req = PRIO_HIGH;
	logic                      out_valid;
	logic                      out_stall    = 1'b0;
	logic signed [DATA_W-1:0]  data_out;
	logic [1:0]                status;
	logic [OCC_W-1:0]          occupancy;

	// Model state of the two rings.
	logic [DATA_W-1:0] high_ring [QUEUE_DEPTH];
	logic [DATA_W-1:0] low_ring  [QUEUE_DEPTH];
	int                high_rd, high_wr, high_cnt;
	int                low_rd, low_wr, low_cnt;

	tpq_result_t expected_beats [$];
	int          mismatches  = 0;
	int          cycle_count = 0;
	int          stall_left  = 0;
	bit          idle_on     = 1'b0;

	two_class_priority_queue_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_out     (data_out),
		.status       (status),
		.occupancy    (occupancy)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	// Advances the ring model by one request and returns the result it yields.
	task automatic priority_queue_step(input logic op, input logic [DATA_W-1:0] val,
			input logic [1:0] prio, output tpq_result_t res);
		res.data = '0;
		res.stat = ST_OK;
		if (op == MODE_ENQ) begin
			if (prio == PRIO_HIGH) begin
				if (high_cnt == QUEUE_DEPTH) begin
					res.stat = ST_FULL;
				end else begin
					high_ring[high_wr] = val;
					high_wr = (high_wr + 1) % QUEUE_DEPTH;
					high_cnt++;
				end
			end else if (prio == PRIO_LOW) begin
				if (low_cnt == QUEUE_DEPTH) begin
					res.stat = ST_FULL;
				end else begin
					low_ring[low_wr] = val;
					low_wr = (low_wr + 1) % QUEUE_DEPTH;
					low_cnt++;
				end
			end else begin
				res.stat = ST_BADPRIO;
			end
		end else if (high_cnt != 0) begin
			res.data = high_ring[high_rd];
			high_rd = (high_rd + 1) % QUEUE_DEPTH;
			high_cnt--;
		end else if (low_cnt != 0) begin
			res.data = low_ring[low_rd];
			low_rd = (low_rd + 1) % QUEUE_DEPTH;
			low_cnt--;
		end else begin
			res.stat = ST_EMPTY;
		end
		res.occ = OCC_W'(high_cnt + low_cnt);
	endtask

	// Presents one request beat, holds it until accepted, then records its result.
	task automatic send_request(input logic op, input logic [DATA_W-1:0] val,
			input logic [1:0] prio, input logic typed, input tpq_result_t typed_res);
		tpq_result_t predicted;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= op;
		value        <= val;
		priority_req <= prio;
		do @(posedge clk); while (in_stall);
		priority_queue_step(op, val, prio, predicted);
		expected_beats.push_back(typed ? typed_res : predicted);
	endtask

	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		tpq_result_t typed_res;
		phase_kind_t phase;
		logic        op;
		logic [1:0]  prio;
		logic [1:0]  target;
		int          phase_len;
		int          sent;
		int          pick;

		high_rd = 0; high_wr = 0; high_cnt = 0;
		low_rd  = 0; low_wr  = 0; low_cnt  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		foreach (dir_rows[r]) begin
			typed_res = '{data: dir_rows[r].data, stat: dir_rows[r].stat, occ: dir_rows[r].occ};
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				send_request(dir_rows[r].op, dir_rows[r].val + k, dir_rows[r].prio,
					dir_rows[r].typed, typed_res);
			end
		end

		// Fill phases push a class toward full; drain phases work the queue back toward empty.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase     = phase_kind_t'($urandom_range(0, 3));
			phase_len = $urandom_range(4, 40);
			idle_on   = ($urandom_range(0, 3) != 0);
			target    = (phase == PH_FILL_HIGH) ? PRIO_HIGH : PRIO_LOW;
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				case (phase)
					PH_FILL_HIGH, PH_FILL_LOW: begin
						op   = ($urandom_range(0, 9) == 0) ? MODE_DEQ : MODE_ENQ;
						pick = $urandom_range(0, 19);
						if (pick < 16) begin
							prio = target;
						end else if (pick < 19) begin
							prio = (target == PRIO_HIGH) ? PRIO_LOW : PRIO_HIGH;
						end else begin
							prio = $urandom_range(0, 1) ? PRIO_BAD_THREE : PRIO_BAD_ZERO;
						end
					end
					PH_DRAIN: begin
						op   = ($urandom_range(0, 9) == 0) ? MODE_ENQ : MODE_DEQ;
						prio = 2'($urandom_range(0, 3));
					end
					default: begin
						op   = 1'($urandom_range(0, 1));
						prio = 2'($urandom_range(0, 3));
					end
				endcase
				if (RANDOM_ITEMS - sent <= CALM_TAIL) begin
					idle_on = 1'b0;
				end
				send_request(op, random_value(), prio, 1'b0, typed_res);
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Result side: check each accepted beat and place random stall bursts.
	always @(posedge clk) begin
		tpq_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat, data_out", data_out, '0);
				end else begin
					want = expected_beats.pop_front();
					if (data_out !== want.data)
						report_mismatch("data_out", data_out, want.data);
					if (status !== want.stat)
						report_mismatch("status", DATA_W'(status), DATA_W'(want.stat));
					if (occupancy !== want.occ)
						report_mismatch("occupancy", DATA_W'(occupancy), DATA_W'(want.occ));
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 9);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
